### rtl/pbbl_pkg.sv
// ----------------------------------------------------------------------------
// pbbl_pkg
// Shared types and codes for the persist buffer with barrier-aware lookup.
// ----------------------------------------------------------------------------
package pbbl_pkg;

  // Default number of entry slots
  localparam int PBBL_DEPTH = 16;

  // Field widths
  localparam int DATA_W      = 64;
  localparam int COUNT_W     = 32;
  localparam int MAX_ENT_W   = 5;
  localparam int SHIFT_W     = 6;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 6;
  localparam int ACTION_W    = 2;
  localparam int STATUS_W    = 3;

  // Register reset values
  localparam logic [MAX_ENT_W-1:0] MAX_ENT_RST   = 5'd16;
  localparam logic [SHIFT_W-1:0]   TAG_SHIFT_RST = 6'd6;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ENTRIES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TAG_SHIFT   = 2'd1;

  // Actions
  localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_ACCESS = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] STAT_INSERTED = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL     = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_REMOVED  = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_EMPTY    = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_HIT      = 3'd4;
  localparam logic [STATUS_W-1:0] STAT_MISS     = 3'd5;

  // One buffer entry, tag in the lowest bits
  typedef struct packed {
    logic              barrier;
    logic [DATA_W-1:0] write_id;
    logic [DATA_W-1:0] addr;
    logic [DATA_W-1:0] tag;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Control for the cell row
  typedef struct packed {
    logic insert;   // load the new entry into the selected cell
    logic shift;    // every cell takes its upper neighbor (ring)
  } chain_ctrl_t;

endpackage

### rtl/pbbl_cell.sv
// ----------------------------------------------------------------------------
// pbbl_cell
// One entry slot: loads a new entry or takes its neighbor's entry.
// ----------------------------------------------------------------------------
module pbbl_cell
  import pbbl_pkg::*;
(
  input  logic   clk,
  input  logic   load,
  input  logic   shift,
  input  entry_t load_data,
  input  entry_t neighbor,
  output entry_t q
);

  // Slot storage, undefined until written
  always_ff @(posedge clk) begin
    if (load) begin
      q <= load_data;
    end else if (shift) begin
      q <= neighbor;
    end
  end

endmodule

### rtl/pbbl_chain.sv
// ----------------------------------------------------------------------------
// pbbl_chain
// Ring of entry cells; cell 0 holds the oldest entry.
// ----------------------------------------------------------------------------
module pbbl_chain
  import pbbl_pkg::*;
#(
  parameter int DEPTH = PBBL_DEPTH,
  parameter int IDXW  = $clog2(DEPTH)
) (
  input  logic             clk,
  input  chain_ctrl_t      ctrl,
  input  logic [IDXW-1:0]  ins_idx,
  input  entry_t           ins_data,
  output entry_t           head
);

  entry_t cell_q [DEPTH];

  // Each cell takes its upper neighbor; the top one wraps to cell 0
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    pbbl_cell u_cell (
      .clk       (clk),
      .load      (ctrl.insert && (ins_idx == IDXW'(i))),
      .shift     (ctrl.shift),
      .load_data (ins_data),
      .neighbor  (cell_q[(i + 1) % DEPTH]),
      .q         (cell_q[i])
    );
  end

  assign head = cell_q[0];

endmodule

### rtl/persist_buffer_barrier_lookup.sv
// ----------------------------------------------------------------------------
// persist_buffer_barrier_lookup
// Bounded write-back FIFO with a barrier-aware tag lookup.
// ----------------------------------------------------------------------------
// Entries live in a ring of DEPTH cells with the oldest in cell 0 while idle.
// Insert, remove and unknown actions give their result in the cycle after the
// accept. For an access, after the accept cycle the ring rotates once around,
// one cell per cycle, past a single tag comparator at cell 0, which leaves the
// entries in their original order. One item is worked on at a time; a waiting
// result holds off the next item until m_axis_tready takes it, though the
// result can leave and the next item enter in the same cycle.
// ----------------------------------------------------------------------------
module persist_buffer_barrier_lookup
  import pbbl_pkg::*;
#(
  parameter int DEPTH = PBBL_DEPTH,
  localparam int IDXW  = $clog2(DEPTH),
  localparam int FILLW = $clog2(DEPTH + 1),
  localparam int IN_W  = ((DATA_W + ENTRY_W) + 7) / 8 * 8,
  localparam int OUT_W = ((ENTRY_W + FILLW + 3 * COUNT_W) + 7) / 8 * 8
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // input items
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // lookup_addr, line_tag, line_addr, line_write_id, line_barrier
  input  logic [IN_W-1:0]       s_axis_tdata,
  // action
  input  logic [ACTION_W-1:0]   s_axis_tuser,
  // result items
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // entry_tag, entry_addr, entry_write_id, entry_barrier, occupancy,
  // insert_count, evict_count, barrier_count
  output logic [OUT_W-1:0]      m_axis_tdata,
  // status
  output logic [STATUS_W-1:0]   m_axis_tuser
);

  localparam int CMPW = (FILLW > MAX_ENT_W) ? FILLW : MAX_ENT_W;

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

  state_t state;

  // Control and configuration registers
  logic [MAX_ENT_W-1:0] max_entries;
  logic [SHIFT_W-1:0]   tag_shift;
  logic [FILLW-1:0]     fill;
  logic [COUNT_W-1:0]   inserts_total;
  logic [COUNT_W-1:0]   evicts_total;
  logic [COUNT_W-1:0]   barriers_total;
  logic [IDXW-1:0]      scan_cnt;
  logic                 matched;
  logic                 blocked;

  // Payload registers
  logic [DATA_W-1:0]    ctag;
  entry_t               found;
  logic [STATUS_W-1:0]  res_status;
  entry_t               res_entry;
  logic [FILLW-1:0]     res_occ;
  logic [COUNT_W-1:0]   res_ins;
  logic [COUNT_W-1:0]   res_ev;
  logic [COUNT_W-1:0]   res_bar;

  // Input fields
  logic [ACTION_W-1:0]  action;
  logic [DATA_W-1:0]    lookup_addr;
  entry_t               line;

  assign action      = s_axis_tuser;
  assign lookup_addr = s_axis_tdata[DATA_W-1:0];
  assign line        = entry_t'(s_axis_tdata[DATA_W +: ENTRY_W]);

  // Handshake
  logic accept;
  assign s_axis_tready = (state == S_IDLE) && (!m_axis_tvalid || m_axis_tready);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Insert / remove decisions
  logic full, is_ins, is_rem;
  assign full   = (CMPW'(fill) >= CMPW'(max_entries)) || (CMPW'(fill) >= CMPW'(DEPTH));
  assign is_ins = accept && (action == ACT_INSERT) && !full;
  assign is_rem = accept && (action == ACT_REMOVE) && (fill != '0);

  // Cell row
  chain_ctrl_t ctrl;
  entry_t      head;

  assign ctrl.insert = is_ins;
  assign ctrl.shift  = is_rem || (state == S_SCAN);

  pbbl_chain #(
    .DEPTH (DEPTH),
    .IDXW  (IDXW)
  ) u_chain (
    .clk      (clk),
    .ctrl     (ctrl),
    .ins_idx  (fill[IDXW-1:0]),
    .ins_data (line),
    .head     (head)
  );

  // Scan step at cell 0
  logic   scan_valid, scan_hit, matched_next, blocked_next, scan_last;
  entry_t found_next;

  assign scan_valid   = FILLW'(scan_cnt) < fill;
  assign scan_hit     = scan_valid && (head.tag == ctag);
  assign matched_next = matched || scan_hit;
  assign blocked_next = blocked || (scan_valid && matched_next && head.barrier);
  assign found_next   = scan_hit ? head : found;
  assign scan_last    = (scan_cnt == IDXW'(DEPTH - 1));

  // Counter updates
  logic [COUNT_W-1:0] inserts_next, evicts_next, barriers_next;
  logic [FILLW-1:0]   fill_next;

  assign inserts_next  = inserts_total + COUNT_W'(1);
  assign evicts_next   = evicts_total + COUNT_W'(1);
  assign barriers_next = line.barrier ? barriers_total + COUNT_W'(1) : barriers_total;
  assign fill_next     = is_ins ? fill + FILLW'(1) :
                         is_rem ? fill - FILLW'(1) : fill;

  // State, counters and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      m_axis_tvalid  <= 1'b0;
      max_entries    <= MAX_ENT_RST;
      tag_shift      <= TAG_SHIFT_RST;
      fill           <= '0;
      inserts_total  <= '0;
      evicts_total   <= '0;
      barriers_total <= '0;
      scan_cnt       <= '0;
      matched        <= 1'b0;
      blocked        <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MAX_ENTRIES: max_entries <= cfg_data[MAX_ENT_W-1:0];
          CFG_TAG_SHIFT:   tag_shift   <= cfg_data[SHIFT_W-1:0];
          default: ;
        endcase
      end

      if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            fill      <= fill_next;
            res_occ   <= fill_next;
            res_entry <= '0;
            res_ins   <= inserts_total;
            res_ev    <= evicts_total;
            res_bar   <= barriers_total;
            case (action)
              ACT_INSERT: begin
                if (is_ins) begin
                  inserts_total  <= inserts_next;
                  barriers_total <= barriers_next;
                  res_ins        <= inserts_next;
                  res_bar        <= barriers_next;
                  res_status     <= STAT_INSERTED;
                end else begin
                  res_status <= STAT_FULL;
                end
                m_axis_tvalid <= 1'b1;
              end
              ACT_REMOVE: begin
                if (is_rem) begin
                  evicts_total <= evicts_next;
                  res_ev       <= evicts_next;
                  res_entry    <= head;
                  res_status   <= STAT_REMOVED;
                end else begin
                  res_status <= STAT_EMPTY;
                end
                m_axis_tvalid <= 1'b1;
              end
              ACT_ACCESS: begin
                ctag     <= lookup_addr >> tag_shift;
                scan_cnt <= '0;
                matched  <= 1'b0;
                blocked  <= 1'b0;
                state    <= S_SCAN;
              end
              default: begin
                res_status    <= STAT_MISS;
                m_axis_tvalid <= 1'b1;
              end
            endcase
          end
        end
        S_SCAN: begin
          scan_cnt <= scan_cnt + IDXW'(1);
          matched  <= matched_next;
          blocked  <= blocked_next;
          found    <= found_next;
          if (scan_last) begin
            // the output register was freed when this access was accepted
            state         <= S_IDLE;
            m_axis_tvalid <= 1'b1;
            if (matched_next && !blocked_next) begin
              res_status <= STAT_HIT;
              res_entry  <= found_next;
            end else begin
              res_status <= STAT_MISS;
              res_entry  <= '0;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Result packing
  assign m_axis_tuser = res_status;
  assign m_axis_tdata = OUT_W'({res_bar, res_ev, res_ins, res_occ, res_entry});

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the persist buffer with barrier-aware lookup.
// ----------------------------------------------------------------------------
// A short table of hand-picked items runs first, then random traffic over
// several limit and shift settings. Every accepted item goes through a
// behavioral copy of the buffer. The copy's result, or a typed table row's
// expected result, is queued and compared, field by field, with each result
// the block hands out. Random traffic mostly looks up tags that are held, so
// hits, youngest-match selection and barrier blocking all occur often.
// ----------------------------------------------------------------------------
module testbench;
  import pbbl_pkg::*;

  localparam int DEPTH = PBBL_DEPTH;
  localparam int IN_W  = ((DATA_W + ENTRY_W) + 7) / 8 * 8;
  localparam int OUT_W = ((ENTRY_W + $clog2(DEPTH + 1) + 3 * COUNT_W) + 7) / 8 * 8;
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
  localparam int NUM_PHASES = 7;
  localparam int PHASE_ITEMS = 290;
  localparam int SETTLE_CYCLES = DEPTH + 4;
  localparam int HOLD_OFF_CYCLES = 80;

  // limit, shift, insert share and idling mode of each random phase
  localparam int PH_LIMIT[NUM_PHASES] = '{16, 1, 31, 0, 16, 5, 8};
  localparam int PH_SHIFT[NUM_PHASES] = '{6, 0, 63, 33, 12, 48, 1};
  localparam int PH_INS[NUM_PHASES]   = '{50, 50, 55, 40, 45, 45, 35};
  localparam int PH_MODE[NUM_PHASES]  = '{0, 0, 1, 1, 2, 2, 2};

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [63:0]         lookup;
    logic [63:0]         tag;
    logic [63:0]         addr;
    logic [63:0]         wid;
    logic                bar;
  } op_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [63:0]         tag;
    logic [63:0]         addr;
    logic [63:0]         wid;
    logic                bar;
    logic [4:0]          occ;
    logic [31:0]         ins;
    logic [31:0]         ev;
    logic [31:0]         bc;
  } outcome_t;

  typedef struct {
    op_t      op;
    bit       typed;
    outcome_t want;
  } dir_row_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_W-1:0]       s_axis_tdata;
  logic [ACTION_W-1:0]   s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_W-1:0]      m_axis_tdata;
  logic [STATUS_W-1:0]   m_axis_tuser;

  // Behavioral copy of the buffer
  logic [63:0] held_tag[DEPTH];
  logic [63:0] held_addr[DEPTH];
  logic [63:0] held_wid[DEPTH];
  logic        held_bar[DEPTH];
  int          rd_ptr;
  int          wr_ptr;
  int          held_count;
  logic [31:0] n_inserts;
  logic [31:0] n_evicts;
  logic [31:0] n_barriers;
  logic [4:0]  limit_reg;
  logic [5:0]  shift_reg;

  outcome_t    awaited_results[$];
  dir_row_t    directed_rows[$];
  logic [63:0] tag_pool[8];
  int          outcome_tally[8];
  int          mismatches;
  int          items_sent;
  int          snd_idle_pct;
  int          rcv_idle_pct;
  bit          stall_request;

  persist_buffer_barrier_lookup #(.DEPTH(DEPTH)) uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Clock
  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Watchdog
  initial begin
    #2000000;
    $display("FAIL persist_buffer_barrier_lookup");
    $finish;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // One step of the buffer: updates the copy and returns the result item
  function automatic outcome_t buffer_step(op_t op);
    outcome_t r;
    logic [63:0] probe;
    int p;
    int found;
    bit matched;
    bit blocked;
    r = '0;
    r.status = STAT_MISS;
    case (op.action)
      ACT_INSERT: begin
        if (held_count >= limit_reg || held_count >= DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          held_tag[wr_ptr]  = op.tag;
          held_addr[wr_ptr] = op.addr;
          held_wid[wr_ptr]  = op.wid;
          held_bar[wr_ptr]  = op.bar;
          wr_ptr = (wr_ptr + 1) % DEPTH;
          held_count++;
          n_inserts++;
          if (op.bar) n_barriers++;
          r.status = STAT_INSERTED;
        end
      end
      ACT_REMOVE: begin
        if (held_count == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          r.tag  = held_tag[rd_ptr];
          r.addr = held_addr[rd_ptr];
          r.wid  = held_wid[rd_ptr];
          r.bar  = held_bar[rd_ptr];
          rd_ptr = (rd_ptr + 1) % DEPTH;
          held_count--;
          n_evicts++;
          r.status = STAT_REMOVED;
        end
      end
      ACT_ACCESS: begin
        // oldest to youngest; a barrier at or after the oldest match blocks
        probe = op.lookup >> shift_reg;
        matched = 0;
        blocked = 0;
        found = 0;
        for (int i = 0; i < held_count; i++) begin
          p = (rd_ptr + i) % DEPTH;
          if (held_tag[p] == probe) begin
            matched = 1;
            found = p;
          end
          if (matched && held_bar[p]) blocked = 1;
        end
        if (matched && !blocked) begin
          r.tag  = held_tag[found];
          r.addr = held_addr[found];
          r.wid  = held_wid[found];
          r.bar  = held_bar[found];
          r.status = STAT_HIT;
        end
      end
      default: ;
    endcase
    r.occ = held_count[4:0];
    r.ins = n_inserts;
    r.ev  = n_evicts;
    r.bc  = n_barriers;
    outcome_tally[r.status]++;
    return r;
  endfunction

  task automatic note_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    mismatches++;
    if (mismatches <= 40)
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
  endtask

  // Result checker
  always @(posedge clk) begin : check_result
    outcome_t got;
    outcome_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.status = m_axis_tuser;
      got.tag    = m_axis_tdata[63:0];
      got.addr   = m_axis_tdata[127:64];
      got.wid    = m_axis_tdata[191:128];
      got.bar    = m_axis_tdata[192];
      got.occ    = m_axis_tdata[197:193];
      got.ins    = m_axis_tdata[229:198];
      got.ev     = m_axis_tdata[261:230];
      got.bc     = m_axis_tdata[293:262];
      if (awaited_results.size() == 0) begin
        note_mismatch("result with nothing pending", {61'd0, got.status}, 64'd0);
      end else begin
        want = awaited_results.pop_front();
        if (got.status !== want.status)
          note_mismatch("status", 64'(got.status), 64'(want.status));
        if (got.tag !== want.tag) note_mismatch("entry_tag", got.tag, want.tag);
        if (got.addr !== want.addr) note_mismatch("entry_addr", got.addr, want.addr);
        if (got.wid !== want.wid) note_mismatch("entry_write_id", got.wid, want.wid);
        if (got.bar !== want.bar)
          note_mismatch("entry_barrier", 64'(got.bar), 64'(want.bar));
        if (got.occ !== want.occ)
          note_mismatch("occupancy", 64'(got.occ), 64'(want.occ));
        if (got.ins !== want.ins)
          note_mismatch("insert_count", 64'(got.ins), 64'(want.ins));
        if (got.ev !== want.ev)
          note_mismatch("evict_count", 64'(got.ev), 64'(want.ev));
        if (got.bc !== want.bc)
          note_mismatch("barrier_count", 64'(got.bc), 64'(want.bc));
      end
    end
  end

  // Receiver: random backpressure, plus a long hold-off on request
  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_request) begin
        stall_request = 0;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  // Offer one item; queue its result once the block takes it
  task automatic offer(input op_t op, input bit typed, input outcome_t want);
    outcome_t predicted;
    @(negedge clk);
    while ($urandom_range(99) < snd_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op.action;
    s_axis_tdata  <= {7'd0, op.bar, op.wid, op.addr, op.tag, op.lookup};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predicted = buffer_step(op);
    awaited_results.push_back(typed ? want : predicted);
    items_sent++;
  endtask

  // Stop offering until every result is back and the block is quiet
  task automatic drain();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[CFG_DATA_W-1:0];
    @(posedge clk);
    if (idx == CFG_MAX_ENTRIES) limit_reg = value[4:0];
    else if (idx == CFG_TAG_SHIFT) shift_reg = value[5:0];
  endtask

  function automatic void set_idling(input int mode);
    case (mode)
      0: begin snd_idle_pct = 15; rcv_idle_pct = 56; end
      1: begin snd_idle_pct = 56; rcv_idle_pct = 15; end
      default: begin snd_idle_pct = 0; rcv_idle_pct = 0; end
    endcase
  endfunction

  function automatic void add_row(input logic [ACTION_W-1:0] action,
                                  input logic [63:0] lookup, input logic [63:0] tag,
                                  input logic [63:0] addr, input logic [63:0] wid,
                                  input logic bar, input bit typed, input outcome_t want);
    dir_row_t row;
    row.op = '{action, lookup, tag, addr, wid, bar};
    row.typed = typed;
    row.want = want;
    directed_rows.push_back(row);
  endfunction

  // Random item: inserts from a small tag pool, lookups mostly on held tags
  function automatic op_t random_op(input int ins_pct);
    op_t op;
    logic [63:0] t;
    logic [63:0] low_mask;
    int r;
    op = '{ACT_UNUSED, rand64(), rand64(), rand64(), rand64(), 1'b0};
    op.bar = $urandom_range(1);
    r = $urandom_range(99);
    if (r < ins_pct) begin
      op.action = ACT_INSERT;
      op.bar = ($urandom_range(99) < 15);
      if ($urandom_range(3) != 0) op.tag = tag_pool[$urandom_range(7)];
    end else if (r < ins_pct + 25) begin
      op.action = ACT_REMOVE;
    end else if (r < 96) begin
      op.action = ACT_ACCESS;
      if ($urandom_range(9) != 0) begin
        if (held_count > 0 && $urandom_range(9) < 7)
          t = held_tag[(rd_ptr + $urandom_range(held_count - 1)) % DEPTH];
        else
          t = tag_pool[$urandom_range(7)];
        low_mask = (64'd1 << shift_reg) - 64'd1;
        op.lookup = (t << shift_reg) | (rand64() & low_mask);
      end
    end
    return op;
  endfunction

  // Main sequence
  initial begin : stimulus
    outcome_t none;
    outcome_t w;
    logic [63:0] ones;
    none = '0;
    ones = ~64'd0;
    mismatches = 0;
    items_sent = 0;
    stall_request = 0;
    foreach (outcome_tally[i]) outcome_tally[i] = 0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = CFG_MAX_ENTRIES;
    cfg_data = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = ACT_INSERT;
    rd_ptr = 0;
    wr_ptr = 0;
    held_count = 0;
    n_inserts = '0;
    n_evicts = '0;
    n_barriers = '0;
    limit_reg = MAX_ENT_RST;
    shift_reg = TAG_SHIFT_RST;
    set_idling(0);
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed table, reset settings (limit 16, shift 6)
    w = none; w.status = STAT_EMPTY;
    add_row(ACT_REMOVE, 64'd0, 64'd0, 64'd0, 64'd0, 1'b0, 1, w);
    w = none; w.status = STAT_MISS;
    add_row(ACT_ACCESS, ones, ones, ones, ones, 1'b1, 1, w);
    add_row(ACT_UNUSED, ones, ones, ones, ones, 1'b1, 1, w);
    w = none; w.status = STAT_INSERTED; w.occ = 5'd1; w.ins = 32'd1;
    add_row(ACT_INSERT, 64'd0, 64'd5, ones, ones, 1'b0, 1, w);
    w = '{STAT_HIT, 64'd5, ones, ones, 1'b0, 5'd1, 32'd1, 32'd0, 32'd0};
    add_row(ACT_ACCESS, (64'd5 << 6) | 64'h3F, 64'd0, 64'd0, 64'd0, 1'b0, 1, w);
    // duplicate tag: the younger copy wins
    add_row(ACT_INSERT, 64'd0, 64'd5, 64'h10, 64'd2, 1'b0, 0, none);
    add_row(ACT_ACCESS, 64'd5 << 6, 64'd0, 64'd0, 64'd0, 1'b0, 0, none);
    // barrier behind both matches blocks them; a matching barrier blocks itself
    add_row(ACT_INSERT, 64'd0, ones >> 6, 64'd0, 64'd0, 1'b1, 0, none);
    add_row(ACT_ACCESS, 64'd5 << 6, 64'd0, 64'd0, 64'd0, 1'b0, 0, none);
    add_row(ACT_ACCESS, ones, 64'd0, 64'd0, 64'd0, 1'b0, 0, none);
    add_row(ACT_REMOVE, 64'd0, 64'd0, 64'd0, 64'd0, 1'b0, 0, none);
    add_row(ACT_REMOVE, 64'd0, 64'd0, 64'd0, 64'd0, 1'b0, 0, none);
    add_row(ACT_ACCESS, ones, 64'd0, 64'd0, 64'd0, 1'b0, 0, none);
    add_row(ACT_INSERT, 64'd0, 64'd0, 64'd0, 64'd0, 1'b0, 0, none);
    add_row(ACT_ACCESS, 64'd0, 64'd0, 64'd0, 64'd0, 1'b0, 0, none);
    add_row(ACT_REMOVE, 64'd0, 64'd0, 64'd0, 64'd0, 1'b0, 0, none);
    add_row(ACT_REMOVE, 64'd0, 64'd0, 64'd0, 64'd0, 1'b0, 0, none);
    add_row(ACT_REMOVE, 64'd0, 64'd0, 64'd0, 64'd0, 1'b0, 0, none);
    foreach (directed_rows[i]) offer(directed_rows[i].op, directed_rows[i].typed,
                                     directed_rows[i].want);

    // Random phases, each under its own register settings
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain();
      write_reg(CFG_MAX_ENTRIES, PH_LIMIT[ph]);
      write_reg(CFG_TAG_SHIFT, PH_SHIFT[ph]);
      @(negedge clk);
      cfg_we <= 1'b0;
      set_idling(PH_MODE[ph]);
      foreach (tag_pool[i]) tag_pool[i] = rand64() & (ones >> shift_reg);
      tag_pool[0] = 64'd0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 4 && n == 40) stall_request = 1;
        if (ph == 1 && n == 150) drain();
        offer(random_op(PH_INS[ph]), 0, none);
      end
    end
    drain();

    $display("ran %0d items over %0d register settings", items_sent, NUM_PHASES + 1);
    $display("inserted %0d, refused %0d, removed %0d, empty %0d, hit %0d, miss %0d",
             outcome_tally[STAT_INSERTED], outcome_tally[STAT_FULL],
             outcome_tally[STAT_REMOVED], outcome_tally[STAT_EMPTY],
             outcome_tally[STAT_HIT], outcome_tally[STAT_MISS]);
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("PASS persist_buffer_barrier_lookup");
    end else begin
      $display("FAIL persist_buffer_barrier_lookup");
    end
    $finish;
  end

endmodule
